### hw/rtl/waveform_oscillator_mixer_assert.svh
// Assertion macros shared by the oscillator mixer RTL.
`ifndef WAVEFORM_OSCILLATOR_MIXER_ASSERT_SVH
`define WAVEFORM_OSCILLATOR_MIXER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define WOM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define WOM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/wom_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wom_pkg;

  // Default geometry
  localparam int DEFAULT_SINE_TABLE_DEPTH = 1024;
  localparam int DEFAULT_PHASE_BITS       = 32;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int AMP_W      = 16;
  localparam int WAVE_W     = 18;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int INC_W      = 32;
  localparam int WSEL_W     = 2;
  localparam int MASK_W     = 2;

  // pi/2 in Q30 for the table series
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WAVE_W-1:0]   wave_t;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INCREMENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK    = 2'd3;

  // Waveform codes
  localparam logic [WSEL_W-1:0] WAVE_SINE   = 2'd0;
  localparam logic [WSEL_W-1:0] WAVE_SQUARE = 2'd1;
  localparam logic [WSEL_W-1:0] WAVE_SAW    = 2'd2;
  localparam logic [WSEL_W-1:0] WAVE_SILENT = 2'd3;

  localparam logic [MASK_W-1:0] MASK_RESET = 2'b11;

endpackage

`default_nettype wire

### hw/rtl/wom_sine_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module wom_sine_rom
  import wom_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = DEFAULT_SINE_TABLE_DEPTH,
  parameter int ADDR_W           = $clog2(SINE_TABLE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output sample_t                rd_data
);

  // One series step: term * x^2 in Q30
  function automatic longint unsigned series_step(input longint unsigned term,
                                                  input longint unsigned x);
    longint unsigned t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  // round(32767 * sin((pi/2) * m / depth)), Taylor series in Q30
  function automatic sample_t quarter_sine(input longint unsigned m);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          r;
    x    = (HALF_PI_Q30 * m) / SINE_TABLE_DEPTH;
    term = x;
    sum  = longint'(x);
    term = series_step(term, x) / 6;
    sum  = sum - longint'(term);
    term = series_step(term, x) / 20;
    sum  = sum + longint'(term);
    term = series_step(term, x) / 42;
    sum  = sum - longint'(term);
    term = series_step(term, x) / 72;
    sum  = sum + longint'(term);
    term = series_step(term, x) / 110;
    sum  = sum - longint'(term);
    term = series_step(term, x) / 156;
    sum  = sum + longint'(term);
    term = series_step(term, x) / 210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    r = longint'(((unsigned'(sum) * 64'd32767) + (64'd1 << 29)) >> 30);
    if (r > 32767) begin
      r = 32767;
    end
    return sample_t'(r);
  endfunction

  // Full period by quarter-wave folding
  function automatic sample_t sine_entry(input longint unsigned k);
    longint unsigned n4;
    longint unsigned q;
    longint unsigned r;
    sample_t         v;
    n4 = 4 * k;
    q  = n4 / SINE_TABLE_DEPTH;
    r  = n4 % SINE_TABLE_DEPTH;
    if (q == 0 || q == 2) begin
      v = quarter_sine(r);
    end else begin
      v = quarter_sine(unsigned'(longint'(SINE_TABLE_DEPTH)) - r);
    end
    return (q >= 2) ? -v : v;
  endfunction

  sample_t sine_rom [SINE_TABLE_DEPTH];

  // Fill the table with constants at elaboration
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_entry
    localparam sample_t ENTRY = sine_entry(unsigned'(longint'(k)));
    assign sine_rom[k] = ENTRY;
  end

  // Registered read; hold the data while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= sine_rom[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/waveform_oscillator_mixer.sv
// Oscillator mixer: adds a sine, square or sawtooth tone into a stereo stream.
// Input channel: in_valid / in_stall with left_in, right_in, last_frame; one
//   stereo frame per beat. Output channel: out_valid / out_stall with
//   left_out, right_out, last_out; one frame out for every frame in, in order.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; always
//   ready. Write registers only while no frame is in flight.
// A frame accepted into stage A moves on through stage B and then the output stage.
// Throughput: one frame per cycle while out_stall is low. The sine table read is
//   registered at the accept edge, the wave multiply has a stage of its own, the
//   saturating mix has the output stage.
// Each frame uses the phase before its advance; the phase then steps by the
//   increment, or returns to zero after a frame marked last.
// Reset clears the pipeline and phase, and sets increment 0, amplitude 0,
//   sine wave, both channels mixed.
// When the receiver stalls, the output beat holds and the stages behind it
//   fill; in_stall rises only once every stage holds a frame.
`timescale 1ns / 1ps
`default_nettype none
`include "waveform_oscillator_mixer_assert.svh"

module waveform_oscillator_mixer
  import wom_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = DEFAULT_SINE_TABLE_DEPTH,
  parameter int PHASE_BITS       = DEFAULT_PHASE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration writes
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Input frames
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire sample_t               left_in,
  input  wire sample_t               right_in,
  input  wire logic                  last_frame,
  // Output frames
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      sample_t               left_out,
  output      sample_t               right_out,
  output      logic                  last_out
);

  localparam int ADDR_W    = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_PW    = PHASE_BITS + ADDR_W + 1;
  localparam int INC_EXT_W = (PHASE_BITS > INC_W) ? PHASE_BITS : INC_W;
  localparam int SAW_PW    = AMP_W + PHASE_BITS + 1;

  // Configuration registers
  logic [INC_W-1:0]  phase_increment;
  logic [AMP_W-1:0]  amplitude;
  logic [WSEL_W-1:0] waveform;
  logic [MASK_W-1:0] channel_mask;

  // Phase
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_next;
  logic [INC_EXT_W-1:0]  inc_ext;
  logic [PHASE_BITS-1:0] inc;
  logic [IDX_PW-1:0]     idx_prod;
  logic [ADDR_W-1:0]     rom_addr;
  sample_t               rom_data;

  // Pipeline
  logic                  in_accept;
  logic                  a_valid;
  logic                  a_ready;
  sample_t               a_left;
  sample_t               a_right;
  logic                  a_last;
  logic [PHASE_BITS-1:0] a_phase;
  logic                  b_valid;
  logic                  b_ready;
  sample_t               b_left;
  sample_t               b_right;
  logic                  b_last;
  wave_t                 b_wave;
  logic                  out_ready;

  // Wave generation
  logic signed [32:0]     sine_prod;
  logic signed [32:0]     sine_bias;
  wave_t                  sine_w;
  wave_t                  amp_w;
  wave_t                  square_w;
  logic [PHASE_BITS:0]    saw_twice;
  logic [PHASE_BITS:0]    saw_full;
  logic                   saw_neg;
  logic [PHASE_BITS:0]    saw_d;
  logic [SAW_PW-1:0]      saw_prod;
  wave_t                  saw_mag;
  wave_t                  saw_w;
  wave_t                  wave_val;

  // Saturating add of the wave into one channel
  function automatic sample_t mix_sample(input sample_t s, input wave_t w, input logic on);
    logic signed [WAVE_W:0] sum;
    sample_t                res;
    sum = (WAVE_W+1)'(s) + (WAVE_W+1)'(w);
    if (!on) begin
      res = s;
    end else if (sum > (WAVE_W+1)'(SAMPLE_MAX)) begin
      res = SAMPLE_MAX;
    end else if (sum < (WAVE_W+1)'(SAMPLE_MIN)) begin
      res = SAMPLE_MIN;
    end else begin
      res = sum[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // Decode configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= '0;
      amplitude       <= '0;
      waveform        <= WAVE_SINE;
      channel_mask    <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_INCREMENT: phase_increment <= cfg_data[INC_W-1:0];
        REG_AMPLITUDE:       amplitude       <= cfg_data[AMP_W-1:0];
        REG_WAVEFORM:        waveform        <= cfg_data[WSEL_W-1:0];
        REG_CHANNEL_MASK:    channel_mask    <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Backpressure chain
  assign out_ready = !out_valid || !out_stall;
  assign b_ready   = !b_valid || out_ready;
  assign a_ready   = !a_valid || b_ready;
  assign in_stall  = !a_ready;
  assign in_accept = in_valid && !in_stall;

  // Advance the phase on each accepted frame
  assign inc_ext    = INC_EXT_W'(phase_increment);
  assign inc        = inc_ext[PHASE_BITS-1:0];
  assign phase_next = last_frame ? '0 : phase_acc + inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (in_accept) begin
      phase_acc <= phase_next;
    end
  end

  // Table index from the current phase
  assign idx_prod = IDX_PW'(phase_acc) * IDX_PW'(SINE_TABLE_DEPTH);
  assign rom_addr = idx_prod[PHASE_BITS +: ADDR_W];

  wom_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .ADDR_W           (ADDR_W)
  ) u_sine_rom (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // Stage A: capture the frame and its phase
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_left  <= left_in;
      a_right <= right_in;
      a_last  <= last_frame;
      a_phase <= phase_acc;
    end
  end

  // Sine: scale by amplitude, truncate toward zero
  assign sine_prod = rom_data * $signed({1'b0, amplitude});
  assign sine_bias = sine_prod + (sine_prod[32] ? 33'sd32767 : 33'sd0);
  assign sine_w    = WAVE_W'(sine_bias >>> 15);

  // Square: sign from the top phase bit
  assign amp_w    = $signed(WAVE_W'(amplitude));
  assign square_w = a_phase[PHASE_BITS-1] ? -amp_w : amp_w;

  // Sawtooth: amplitude * |2p - full| / full, sign from the top phase bit
  assign saw_twice = {a_phase, 1'b0};
  assign saw_full  = {1'b1, {PHASE_BITS{1'b0}}};
  assign saw_neg   = !a_phase[PHASE_BITS-1];
  assign saw_d     = saw_neg ? (saw_full - saw_twice) : (saw_twice - saw_full);
  assign saw_prod  = SAW_PW'(amplitude) * SAW_PW'(saw_d);
  assign saw_mag   = $signed(WAVE_W'(saw_prod[PHASE_BITS +: AMP_W]));
  assign saw_w     = saw_neg ? -saw_mag : saw_mag;

  // Pick the wave
  always_comb begin
    case (waveform)
      WAVE_SINE:   wave_val = sine_w;
      WAVE_SQUARE: wave_val = square_w;
      WAVE_SAW:    wave_val = saw_w;
      WAVE_SILENT: wave_val = '0;
      default:     wave_val = '0;
    endcase
  end

  // Stage B: hold the wave value
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_left  <= a_left;
      b_right <= a_right;
      b_last  <= a_last;
      b_wave  <= wave_val;
    end
  end

  // Output stage: saturating mix
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && b_valid) begin
      left_out  <= mix_sample(b_left, b_wave, channel_mask[0]);
      right_out <= mix_sample(b_right, b_wave, channel_mask[1]);
      last_out  <= b_last;
    end
  end

  // Checks
  `WOM_ASSERT_NEXT(a_phase_clear, clk, rst, in_accept && last_frame, phase_acc == '0,
    "phase not cleared after last frame")
  `WOM_ASSERT_NEXT(a_phase_step, clk, rst, in_accept && !last_frame,
    phase_acc == $past(phase_acc) + $past(inc), "phase did not advance by increment")
  `WOM_ASSERT_IMPLY(a_stall_full, clk, rst, in_stall, a_valid && b_valid && out_valid,
    "input stalled with an empty stage")
  `WOM_ASSERT_NEXT(a_stage_move, clk, rst, a_valid && b_ready, b_valid,
    "frame lost between stage A and stage B")

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import wom_pkg::*;

  localparam int TABLE_DEPTH  = DEFAULT_SINE_TABLE_DEPTH;
  localparam int PHASE_W      = DEFAULT_PHASE_BITS;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_RUNS  = 8;
  localparam int RUN_FRAMES   = 50;

  // Channel mask settings besides the reset value
  localparam logic [MASK_W-1:0] MIX_NONE  = 2'b00;
  localparam logic [MASK_W-1:0] MIX_LEFT  = 2'b01;
  localparam logic [MASK_W-1:0] MIX_RIGHT = 2'b10;

  typedef struct {
    sample_t left;
    sample_t right;
    logic    last;
  } frame_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  sample_t               left_in;
  sample_t               right_in;
  logic                  last_frame;
  logic                  out_valid;
  logic                  out_stall;
  sample_t               left_out;
  sample_t               right_out;
  logic                  last_out;

  // Oscillator state as the block should hold it
  logic [PHASE_W-1:0] phase_acc;
  logic [INC_W-1:0]   step_reg;
  logic [AMP_W-1:0]   level_reg;
  logic [WSEL_W-1:0]  shape_reg;
  logic [MASK_W-1:0]  mix_reg;
  int                 sine_lut [TABLE_DEPTH];

  frame_t expected_frames [$];
  int     error_count;
  int     cycle_count;
  bit     quiet;

  waveform_oscillator_mixer u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .left_in    (left_in),
    .right_in   (right_in),
    .last_frame (last_frame),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .left_out   (left_out),
    .right_out  (right_out),
    .last_out   (last_out)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // round(32767 * sin(pi/2 * m / depth)) from an eight-term Q30 series
  function automatic int quarter_wave(longint unsigned m);
    longint unsigned x;
    longint unsigned term;
    longint unsigned rounded;
    longint          acc;
    x = (HALF_PI_Q30 * m) / TABLE_DEPTH;
    term = x;
    acc = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc -= term;
      else acc += term;
    end
    if (acc < 0) acc = 0;
    rounded = (unsigned'(acc) * 64'd32767 + 64'd536870912) >> 30;
    if (rounded > 32767) rounded = 32767;
    return int'(rounded);
  endfunction

  function automatic void fill_sine_lut();
    int quad;
    int rem;
    int v;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      quad = (4 * k) / TABLE_DEPTH;
      rem  = (4 * k) % TABLE_DEPTH;
      if (quad == 0 || quad == 2) v = quarter_wave(rem);
      else v = quarter_wave(TABLE_DEPTH - rem);
      sine_lut[k] = (quad >= 2) ? -v : v;
    end
  endfunction

  // Wave value at the current phase, before the saturating mix
  function automatic longint tone_value();
    longint unsigned p;
    longint unsigned idx;
    longint unsigned full;
    longint unsigned twice;
    longint unsigned span;
    longint unsigned mag;
    longint          a;
    p = {{(64-PHASE_W){1'b0}}, phase_acc};
    a = longint'({48'd0, level_reg});
    full = 64'd1 << PHASE_W;
    case (shape_reg)
      WAVE_SINE: begin
        idx = (p * TABLE_DEPTH) >> PHASE_W;
        if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
        return (longint'(sine_lut[idx]) * a) / 32768;
      end
      WAVE_SQUARE: begin
        return (p < (full >> 1)) ? a : -a;
      end
      WAVE_SAW: begin
        twice = 2 * p;
        span = (twice < full) ? (full - twice) : (twice - full);
        mag = ({48'd0, level_reg} * span) >> PHASE_W;
        return (twice < full) ? -longint'(mag) : longint'(mag);
      end
      default: return 0;
    endcase
  endfunction

  function automatic sample_t mix_sample(sample_t s, longint w, logic on);
    longint v;
    v = s;
    if (on) begin
      v += w;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // Queue the output for one accepted frame, then advance the phase
  function automatic void predict_frame(sample_t l, sample_t r, logic lst);
    frame_t f;
    longint w;
    w = tone_value();
    f.left  = mix_sample(l, w, mix_reg[0]);
    f.right = mix_sample(r, w, mix_reg[1]);
    f.last  = lst;
    expected_frames.push_back(f);
    if (lst) phase_acc = '0;
    else phase_acc = phase_acc + step_reg[PHASE_W-1:0];
  endfunction

  // Check each output beat against the oldest expected frame; stall at random
  always @(posedge clk) begin : check_output
    frame_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          error_count++;
          $display("%0t: unexpected frame left %0d right %0d last %0b",
                   $time, left_out, right_out, last_out);
        end else begin
          want = expected_frames.pop_front();
          if (left_out !== want.left) begin
            error_count++;
            $display("%0t: left_out expected %0d got %0d", $time, want.left, left_out);
          end
          if (right_out !== want.right) begin
            error_count++;
            $display("%0t: right_out expected %0d got %0d", $time, want.right, right_out);
          end
          if (last_out !== want.last) begin
            error_count++;
            $display("%0t: last_out expected %0b got %0b", $time, want.last, last_out);
          end
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < 9);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("waveform_oscillator_mixer regression: fail");
      $finish;
    end
  end

  // Hold one register write until the block takes it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PHASE_INCREMENT: step_reg  = data[INC_W-1:0];
      REG_AMPLITUDE:       level_reg = data[AMP_W-1:0];
      REG_WAVEFORM:        shape_reg = data[WSEL_W-1:0];
      REG_CHANNEL_MASK:    mix_reg   = data[MASK_W-1:0];
      default: ;
    endcase
  endtask

  // Write all four registers; unused upper data bits carry noise
  task automatic configure(logic [INC_W-1:0] inc, logic [AMP_W-1:0] amp,
                           logic [WSEL_W-1:0] shape, logic [MASK_W-1:0] mix);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_PHASE_INCREMENT, inc);
    write_reg(REG_AMPLITUDE, {junk[31:16], amp});
    write_reg(REG_WAVEFORM, {junk[31:2], shape});
    write_reg(REG_CHANNEL_MASK, {junk[29:0], mix});
    cfg_valid <= 1'b0;
  endtask

  // Send one frame, with random idle cycles ahead of it unless quiet
  task automatic send_frame(sample_t l, sample_t r, logic lst);
    if (!quiet)
      while ($urandom_range(99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid   <= 1'b1;
    left_in    <= l;
    right_in   <= r;
    last_frame <= lst;
    do @(posedge clk); while (in_stall);
    predict_frame(l, r, lst);
  endtask

  // Hold the sender until every expected frame has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_frames.size() != 0);
  endtask

  // Reset settings: zero amplitude, so samples pass unchanged
  task automatic test_reset_state();
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_frame(16'sd0, -16'sd1, 1'b1);
    drain();
  endtask

  // Full-scale square saturates both ways; phase restarts after a last frame
  task automatic test_square_saturation();
    configure(32'h4000_0000, 16'h8000, WAVE_SQUARE, MASK_RESET);
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_frame(16'sd0, 16'sd0, 1'b0);
    send_frame(SAMPLE_MIN, 16'sd1, 1'b0);
    send_frame(-16'sd1, SAMPLE_MAX, 1'b1);
    send_frame(16'sd0, 16'sd0, 1'b0);
    send_frame(16'sd100, -16'sd100, 1'b0);
    drain();
  endtask

  // Amplitude above full scale on a sawtooth, left channel only
  task automatic test_saw_overscale();
    configure(32'h8000_0000, 16'hFFFF, WAVE_SAW, MIX_LEFT);
    send_frame(16'sd0, SAMPLE_MAX, 1'b0);
    send_frame(16'sd0, SAMPLE_MIN, 1'b0);
    send_frame(SAMPLE_MAX, 16'sd5, 1'b0);
    drain();
  endtask

  // Sine at the quarter points, then a wrapping increment on the right only
  task automatic test_sine_points();
    configure(32'h4000_0000, 16'h8000, WAVE_SINE, MASK_RESET);
    repeat (4) send_frame(16'sd0, 16'sd0, 1'b0);
    drain();
    configure(32'hFFFF_FFFF, 16'h4000, WAVE_SINE, MIX_RIGHT);
    send_frame(16'sd1234, SAMPLE_MIN, 1'b0);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_frame(-16'sd7, 16'sd0, 1'b0);
    send_frame(16'sd0, -16'sd32000, 1'b1);
    drain();
  endtask

  // Silent wave and an empty mask pass samples through
  task automatic test_pass_through();
    configure(32'h1234_5678, 16'h8000, WAVE_SILENT, MASK_RESET);
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    drain();
    configure(32'h1234_5678, 16'h8000, WAVE_SQUARE, MIX_NONE);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    drain();
  endtask

  function automatic logic [INC_W-1:0] pick_increment();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(1 << 28, 1 << 22);
      4: return $urandom_range(1 << 24, 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [AMP_W-1:0] pick_amplitude();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(4))
      0: return '0;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return r[15:0];
      default: return AMP_W'($urandom_range(32768));
    endcase
  endfunction

  function automatic sample_t pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  // Random runs: each wave twice, random settings, buffers of random length
  task automatic test_random_streams();
    logic [MASK_W-1:0] mix;
    int                buf_left;
    for (int run = 0; run < RANDOM_RUNS; run++) begin
      mix = MASK_W'($urandom_range(3));
      configure(pick_increment(), pick_amplitude(), run[WSEL_W-1:0], mix);
      quiet = (run == 3);
      buf_left = $urandom_range(60, 1);
      for (int i = 0; i < RUN_FRAMES; i++) begin
        buf_left--;
        send_frame(pick_sample(), pick_sample(), buf_left == 0);
        if (buf_left == 0) buf_left = $urandom_range(60, 1);
        if (i == RUN_FRAMES / 2 && run % 2 == 1) drain();
      end
      drain();
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_PHASE_INCREMENT;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    left_in    <= '0;
    right_in   <= '0;
    last_frame <= 1'b0;
    quiet       = 1'b0;
    phase_acc   = '0;
    step_reg    = '0;
    level_reg   = '0;
    shape_reg   = WAVE_SINE;
    mix_reg     = MASK_RESET;
    fill_sine_lut();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_square_saturation();
    test_saw_overscale();
    test_sine_points();
    test_pass_through();
    test_random_streams();

    // Let the pipeline settle after the last frame
    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("waveform_oscillator_mixer regression: pass");
    end else begin
      $display("waveform_oscillator_mixer regression: fail");
    end
    $finish;
  end

endmodule
